// ===== hdl/dbps_pkg.sv =====
package dbps_pkg;

    localparam int SPEED_W  = 24;
    localparam int DIST_W   = 24;
    localparam int HEIGHT_W = 24;
    localparam int K_W      = 24;
    localparam int STATUS_W = 2;
    localparam int PITCH_W  = 20;
    localparam int TIME_W   = 19;

    localparam int MAX_ATTEMPTS_DEF     = 10;
    localparam int MAX_FLIGHT_STEPS_DEF = 800;

    localparam int CORDIC_ITERS = 16;
    localparam int SHIFT_W      = 4;
    localparam int ITER_W       = 5;
    localparam int RATIO_W      = 17;

    localparam int CW  = 48;
    localparam int ZW  = 20;
    localparam int VW  = 32;
    localparam int PW  = 58;
    localparam int KVW = 28;
    localparam int MW  = 61;
    localparam int AW  = 36;
    localparam int UW  = 32;
    localparam int RW  = 33;
    localparam int QW  = 28;
    localparam int REMW = 34;

    localparam logic [15:0]          GAIN        = 16'd39797;
    localparam logic signed [AW-1:0] GRAVITY     = 36'sd642908;
    localparam logic signed [VW-1:0] VX_FLOOR    = 32'sd6554;
    localparam logic signed [VW-1:0] TOLERANCE   = 32'sd66;
    localparam logic signed [ZW-1:0] PITCH_LIMIT = 20'sd91499;
    localparam logic signed [AW-1:0] HALF_STEP   = 36'sd100;
    localparam logic signed [AW-1:0] DIV_BIAS    = 36'sd1677721600;
    localparam logic signed [VW-1:0] DIV_OFFSET  = 32'sd67108864;
    localparam logic [RW-1:0]        RECIP_25    = 33'd5497558138;
    localparam logic [QW+4:0]        DIVISOR_25  = 33'd25;
    localparam logic signed [CW-1:0] ROUND_14    = 48'sd8192;

    typedef enum logic [1:0] {
        ST_SOLVED      = 2'd0,
        ST_BAD_INPUT   = 2'd1,
        ST_NOT_REACHED = 2'd2,
        ST_NO_CONV     = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_AT_INIT,
        OP_CORDIC,
        OP_AT_DONE,
        OP_ROT_INIT,
        OP_ROT_DONE,
        OP_HY_INIT,
        OP_HY_MUL,
        OP_KV,
        OP_MUL,
        OP_DIVA,
        OP_DIVB,
        OP_DV_INIT,
        OP_DV_ITER,
        OP_HIT,
        OP_ERR,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        D_VX,
        D_VY,
        D_X,
        D_Y,
        D_TIME
    } dsel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_AT,
        S_AT_DONE,
        S_PCHK,
        S_ROT_INIT,
        S_ROT,
        S_ROT_DONE,
        S_HY_INIT,
        S_HY,
        S_HY_MUL,
        S_KV,
        S_MUL,
        S_DIVA,
        S_DIVB,
        S_STEP_CHK,
        S_CROSS,
        S_DV,
        S_HIT,
        S_ERR,
        S_ECHK,
        S_EMIT
    } state_t;

    typedef struct packed {
        op_t                 op;
        logic [SHIFT_W-1:0]  iter;
        logic                rot;
        logic                first;
        dsel_t               dsel;
        status_t             status;
    } cmd_t;

    typedef struct packed {
        logic bad_in;
        logic step_end;
        logic no_reach;
        logic err_small;
        logic pitch_over;
    } flags_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [SHIFT_W-1:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            4'd0:    a = 20'sd51472;
            4'd1:    a = 20'sd30385;
            4'd2:    a = 20'sd16055;
            4'd3:    a = 20'sd8150;
            4'd4:    a = 20'sd4091;
            4'd5:    a = 20'sd2047;
            4'd6:    a = 20'sd1024;
            4'd7:    a = 20'sd512;
            4'd8:    a = 20'sd256;
            4'd9:    a = 20'sd128;
            4'd10:   a = 20'sd64;
            4'd11:   a = 20'sd32;
            4'd12:   a = 20'sd16;
            4'd13:   a = 20'sd8;
            4'd14:   a = 20'sd4;
            default: a = 20'sd2;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/dbps_if.sv =====
interface dbps_query_if;
    logic                                 valid;
    logic                                 ready;
    logic [dbps_pkg::SPEED_W-1:0]         muzzle_speed;
    logic [dbps_pkg::DIST_W-1:0]          target_distance;
    logic signed [dbps_pkg::HEIGHT_W-1:0] target_height;

    modport source (output valid, output muzzle_speed, output target_distance,
                    output target_height, input ready);
    modport sink (input valid, input muzzle_speed, input target_distance,
                  input target_height, output ready);
endinterface

interface dbps_answer_if;
    logic                                valid;
    logic                                ready;
    logic [dbps_pkg::STATUS_W-1:0]       status;
    logic signed [dbps_pkg::PITCH_W-1:0] pitch_angle;
    logic [dbps_pkg::TIME_W-1:0]         flight_time;

    modport source (output valid, output status, output pitch_angle,
                    output flight_time, input ready);
    modport sink (input valid, input status, input pitch_angle,
                  input flight_time, output ready);
endinterface

// ===== hdl/dbps_ctrl.sv =====
module dbps_ctrl #(
    parameter int MAX_ATTEMPTS = dbps_pkg::MAX_ATTEMPTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  dbps_pkg::flags_t      flags,
    output dbps_pkg::cmd_t        cmd
);

    localparam int ATT_W = $clog2(MAX_ATTEMPTS + 1);

    dbps_pkg::state_t               state_reg, state_next;
    logic [dbps_pkg::ITER_W-1:0]    iter_reg, iter_next;
    logic [ATT_W-1:0]               attempt_reg, attempt_next;
    logic [ATT_W-1:0]               attempt_inc;
    logic                           first_reg, first_next;
    dbps_pkg::dsel_t                phase_reg, phase_next;
    dbps_pkg::status_t              code_reg, code_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           slot_free;

    assign attempt_inc = attempt_reg + 1'b1;
    assign slot_free   = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dbps_pkg::S_IDLE;
            iter_reg      <= '0;
            attempt_reg   <= '0;
            first_reg     <= 1'b1;
            phase_reg     <= dbps_pkg::D_VX;
            code_reg      <= dbps_pkg::ST_SOLVED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            attempt_reg   <= attempt_next;
            first_reg     <= first_next;
            phase_reg     <= phase_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = '0;
        attempt_next   = attempt_reg;
        first_next     = first_reg;
        phase_next     = phase_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            dbps_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next   = dbps_pkg::S_CHECK;
                    attempt_next = '0;
                    first_next   = 1'b1;
                end
            end
            dbps_pkg::S_CHECK:
            begin
                if (flags.bad_in)
                begin
                    code_next  = dbps_pkg::ST_BAD_INPUT;
                    state_next = dbps_pkg::S_EMIT;
                end
                else
                begin
                    state_next = dbps_pkg::S_AT;
                end
            end
            dbps_pkg::S_AT, dbps_pkg::S_ROT, dbps_pkg::S_HY:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == dbps_pkg::ITER_W'(dbps_pkg::CORDIC_ITERS - 1))
                begin
                    iter_next = '0;
                    case (state_reg)
                        dbps_pkg::S_AT:  state_next = dbps_pkg::S_AT_DONE;
                        dbps_pkg::S_ROT: state_next = dbps_pkg::S_ROT_DONE;
                        default:         state_next = dbps_pkg::S_HY_MUL;
                    endcase
                end
            end
            dbps_pkg::S_AT_DONE:
            begin
                state_next = dbps_pkg::S_PCHK;
            end
            dbps_pkg::S_PCHK:
            begin
                if (first_reg)
                begin
                    first_next = 1'b0;
                    state_next = dbps_pkg::S_ROT_INIT;
                end
                else if (flags.pitch_over || attempt_inc == ATT_W'(MAX_ATTEMPTS))
                begin
                    code_next  = dbps_pkg::ST_NO_CONV;
                    state_next = dbps_pkg::S_EMIT;
                end
                else
                begin
                    attempt_next = attempt_inc;
                    state_next   = dbps_pkg::S_ROT_INIT;
                end
            end
            dbps_pkg::S_ROT_INIT: state_next = dbps_pkg::S_ROT;
            dbps_pkg::S_ROT_DONE: state_next = dbps_pkg::S_HY_INIT;
            dbps_pkg::S_HY_INIT:  state_next = dbps_pkg::S_HY;
            dbps_pkg::S_HY_MUL:   state_next = dbps_pkg::S_KV;
            dbps_pkg::S_KV:
            begin
                phase_next = dbps_pkg::D_VX;
                state_next = dbps_pkg::S_MUL;
            end
            dbps_pkg::S_MUL:  state_next = dbps_pkg::S_DIVA;
            dbps_pkg::S_DIVA: state_next = dbps_pkg::S_DIVB;
            dbps_pkg::S_DIVB:
            begin
                case (phase_reg)
                    dbps_pkg::D_VX:
                    begin
                        phase_next = dbps_pkg::D_VY;
                        state_next = dbps_pkg::S_MUL;
                    end
                    dbps_pkg::D_VY:
                    begin
                        phase_next = dbps_pkg::D_X;
                        state_next = dbps_pkg::S_DIVA;
                    end
                    dbps_pkg::D_X:
                    begin
                        phase_next = dbps_pkg::D_Y;
                        state_next = dbps_pkg::S_DIVA;
                    end
                    dbps_pkg::D_Y:
                    begin
                        state_next = dbps_pkg::S_STEP_CHK;
                    end
                    default:
                    begin
                        code_next  = dbps_pkg::ST_SOLVED;
                        state_next = dbps_pkg::S_EMIT;
                    end
                endcase
            end
            dbps_pkg::S_STEP_CHK:
            begin
                state_next = flags.step_end ? dbps_pkg::S_CROSS : dbps_pkg::S_HY_INIT;
            end
            dbps_pkg::S_CROSS:
            begin
                if (flags.no_reach)
                begin
                    code_next  = dbps_pkg::ST_NOT_REACHED;
                    state_next = dbps_pkg::S_EMIT;
                end
                else
                begin
                    state_next = dbps_pkg::S_DV;
                end
            end
            dbps_pkg::S_DV:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == dbps_pkg::ITER_W'(dbps_pkg::RATIO_W - 1))
                begin
                    iter_next  = '0;
                    state_next = dbps_pkg::S_HIT;
                end
            end
            dbps_pkg::S_HIT: state_next = dbps_pkg::S_ERR;
            dbps_pkg::S_ERR: state_next = dbps_pkg::S_ECHK;
            dbps_pkg::S_ECHK:
            begin
                if (flags.err_small)
                begin
                    phase_next = dbps_pkg::D_TIME;
                    state_next = dbps_pkg::S_DIVA;
                end
                else
                begin
                    state_next = dbps_pkg::S_AT;
                end
            end
            dbps_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = dbps_pkg::S_IDLE;
                end
            end
            default: state_next = dbps_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.op     = dbps_pkg::OP_NOP;
        cmd.iter   = iter_reg[dbps_pkg::SHIFT_W-1:0];
        cmd.rot    = (state_reg == dbps_pkg::S_ROT);
        cmd.first  = first_reg;
        cmd.dsel   = phase_reg;
        cmd.status = code_reg;
        case (state_reg)
            dbps_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = dbps_pkg::OP_LOAD;
                end
            end
            dbps_pkg::S_CHECK:
            begin
                cmd.first = 1'b1;
                if (!flags.bad_in)
                begin
                    cmd.op = dbps_pkg::OP_AT_INIT;
                end
            end
            dbps_pkg::S_AT, dbps_pkg::S_ROT, dbps_pkg::S_HY:
            begin
                cmd.op = dbps_pkg::OP_CORDIC;
            end
            dbps_pkg::S_AT_DONE:  cmd.op = dbps_pkg::OP_AT_DONE;
            dbps_pkg::S_ROT_INIT: cmd.op = dbps_pkg::OP_ROT_INIT;
            dbps_pkg::S_ROT_DONE: cmd.op = dbps_pkg::OP_ROT_DONE;
            dbps_pkg::S_HY_INIT:  cmd.op = dbps_pkg::OP_HY_INIT;
            dbps_pkg::S_HY_MUL:   cmd.op = dbps_pkg::OP_HY_MUL;
            dbps_pkg::S_KV:       cmd.op = dbps_pkg::OP_KV;
            dbps_pkg::S_MUL:      cmd.op = dbps_pkg::OP_MUL;
            dbps_pkg::S_DIVA:     cmd.op = dbps_pkg::OP_DIVA;
            dbps_pkg::S_DIVB:     cmd.op = dbps_pkg::OP_DIVB;
            dbps_pkg::S_CROSS:
            begin
                if (!flags.no_reach)
                begin
                    cmd.op = dbps_pkg::OP_DV_INIT;
                end
            end
            dbps_pkg::S_DV:       cmd.op = dbps_pkg::OP_DV_ITER;
            dbps_pkg::S_HIT:      cmd.op = dbps_pkg::OP_HIT;
            dbps_pkg::S_ERR:      cmd.op = dbps_pkg::OP_ERR;
            dbps_pkg::S_ECHK:
            begin
                cmd.first = 1'b0;
                if (!flags.err_small)
                begin
                    cmd.op = dbps_pkg::OP_AT_INIT;
                end
            end
            dbps_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.op = dbps_pkg::OP_OUT;
                end
            end
            default: cmd.op = dbps_pkg::OP_NOP;
        endcase
    end

endmodule

// ===== hdl/dbps_dp.sv =====
module dbps_dp #(
    parameter int MAX_FLIGHT_STEPS = dbps_pkg::MAX_FLIGHT_STEPS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [dbps_pkg::K_W-1:0]             cfg_write_data,
    input  logic [dbps_pkg::SPEED_W-1:0]         muzzle_speed,
    input  logic [dbps_pkg::DIST_W-1:0]          target_distance,
    input  logic signed [dbps_pkg::HEIGHT_W-1:0] target_height,
    input  dbps_pkg::cmd_t                       cmd,
    output dbps_pkg::flags_t                     flags,
    output logic [dbps_pkg::STATUS_W-1:0]        status,
    output logic signed [dbps_pkg::PITCH_W-1:0]  pitch_angle,
    output logic [dbps_pkg::TIME_W-1:0]          flight_time
);

    localparam int NW = $clog2(MAX_FLIGHT_STEPS + 1);
    localparam int CW = dbps_pkg::CW;
    localparam int ZW = dbps_pkg::ZW;
    localparam int VW = dbps_pkg::VW;
    localparam int AW = dbps_pkg::AW;
    localparam int QW = dbps_pkg::QW;

    logic [dbps_pkg::K_W-1:0]              k_reg;
    logic [dbps_pkg::SPEED_W-1:0]          speed_reg;
    logic [dbps_pkg::DIST_W-1:0]           dist_reg;
    logic signed [dbps_pkg::HEIGHT_W-1:0]  height_reg;
    logic signed [CW-1:0]                  cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ZW-1:0]                  z_reg, z_next, pitch_reg, pitch_next;
    logic signed [VW-1:0]                  vx_reg, vx_next, vy_reg, vy_next;
    logic signed [VW-1:0]                  x_reg, x_next, y_reg, y_next;
    logic signed [VW-1:0]                  px_reg, px_next, py_reg, py_next;
    logic [NW-1:0]                         n_reg, n_next, pn_reg, pn_next;
    logic [dbps_pkg::PW-1:0]               prod_reg, prod_next;
    logic [dbps_pkg::KVW-1:0]              kv_reg, kv_next;
    logic signed [dbps_pkg::MW-1:0]        m_reg, m_next;
    logic [dbps_pkg::UW-1:0]               du_reg, du_next;
    logic [dbps_pkg::UW+dbps_pkg::RW-1:0]  dq_reg, dq_next;
    logic [dbps_pkg::REMW-1:0]             rem_reg, rem_next;
    logic [dbps_pkg::RATIO_W-1:0]          quo_reg, quo_next, nlo_reg, nlo_next;
    logic [VW-1:0]                         den_reg, den_next;
    logic signed [VW-1:0]                  err_reg, err_next;
    logic [dbps_pkg::TIME_W-1:0]           time_reg, time_next;
    logic [dbps_pkg::STATUS_W-1:0]         ost_reg, ost_next;
    logic signed [dbps_pkg::PITCH_W-1:0]   opitch_reg, opitch_next;
    logic [dbps_pkg::TIME_W-1:0]           otime_reg, otime_next;

    logic signed [CW-1:0]                  dx, dy, rnd_x, rnd_y;
    logic signed [ZW-1:0]                  ang;
    logic                                  up;
    logic [VW-1:0]                         ax, ay;
    logic signed [VW-1:0]                  dist_s;
    logic signed [AW-1:0]                  div_a, div_s;
    logic [QW-1:0]                         qe, qc;
    logic [QW+4:0]                         qe25, rmd;
    logic signed [VW-1:0]                  div_res;
    logic [dbps_pkg::REMW-1:0]             trial;
    logic [VW-1:0]                         span;
    logic signed [VW:0]                    dyy;
    logic signed [dbps_pkg::RATIO_W:0]     ratio_s;
    logic signed [VW-1:0]                  hit_y;
    logic [2*dbps_pkg::K_W+3:0]            kvfull;

    assign dist_s  = VW'({1'b0, dist_reg});
    assign dx      = cy_reg >>> cmd.iter;
    assign dy      = cx_reg >>> cmd.iter;
    assign ang     = dbps_pkg::atan_entry(cmd.iter);
    assign up      = cmd.rot ? z_reg[ZW-1] : !cy_reg[CW-1];
    assign ax      = vx_reg[VW-1] ? VW'(-vx_reg) : VW'(vx_reg);
    assign ay      = vy_reg[VW-1] ? VW'(-vy_reg) : VW'(vy_reg);
    assign rnd_x   = cx_reg + dbps_pkg::ROUND_14;
    assign rnd_y   = cy_reg + dbps_pkg::ROUND_14;
    assign kvfull  = k_reg * prod_reg[dbps_pkg::PW-1:30];
    assign span    = VW'(dist_s - px_reg);
    assign trial   = {rem_reg[dbps_pkg::REMW-2:0], nlo_reg[dbps_pkg::RATIO_W-1]};
    assign dyy     = (VW + 1)'(y_reg) - (VW + 1)'(py_reg);
    assign ratio_s = {1'b0, quo_reg};
    assign hit_y   = py_reg + VW'(m_reg >>> 16);

    always_comb
    begin
        case (cmd.dsel)
            dbps_pkg::D_VX:   div_a = AW'(m_reg >>> 16);
            dbps_pkg::D_VY:   div_a = dbps_pkg::GRAVITY + AW'(m_reg >>> 16);
            dbps_pkg::D_X:    div_a = AW'(vx_reg);
            dbps_pkg::D_Y:    div_a = AW'(vy_reg);
            default:          div_a = AW'({pn_reg, 16'b0}) + AW'(quo_reg);
        endcase
    end

    assign div_s   = ((div_a + dbps_pkg::HALF_STEP) >>> 3) + dbps_pkg::DIV_BIAS;
    assign qe      = dq_reg[dbps_pkg::UW+dbps_pkg::RW-1:37];
    assign qe25    = ({5'b0, qe} << 4) + ({5'b0, qe} << 3) + {5'b0, qe};
    assign rmd     = {1'b0, du_reg} - qe25;
    assign qc      = (rmd >= dbps_pkg::DIVISOR_25) ? qe + 1'b1 : qe;
    assign div_res = VW'({4'b0, qc}) - dbps_pkg::DIV_OFFSET;

    always_comb
    begin
        flags.bad_in     = (speed_reg == '0) || (dist_reg == '0);
        flags.step_end   = (n_reg >= NW'(MAX_FLIGHT_STEPS)) || (vx_reg <= dbps_pkg::VX_FLOOR)
                           || !(x_reg < dist_s);
        flags.no_reach   = (x_reg < dist_s) || (x_reg <= px_reg);
        flags.err_small  = (err_reg < dbps_pkg::TOLERANCE) && (err_reg > -dbps_pkg::TOLERANCE);
        flags.pitch_over = (pitch_reg > dbps_pkg::PITCH_LIMIT)
                           || (pitch_reg < -dbps_pkg::PITCH_LIMIT);
    end

    always_comb
    begin
        cx_next = cx_reg;   cy_next = cy_reg;   z_next = z_reg;
        pitch_next = pitch_reg;
        vx_next = vx_reg;   vy_next = vy_reg;   x_next = x_reg;   y_next = y_reg;
        px_next = px_reg;   py_next = py_reg;   n_next = n_reg;   pn_next = pn_reg;
        prod_next = prod_reg;   kv_next = kv_reg;   m_next = m_reg;
        du_next = du_reg;   dq_next = dq_reg;
        rem_next = rem_reg; quo_next = quo_reg; nlo_next = nlo_reg; den_next = den_reg;
        err_next = err_reg; time_next = time_reg;
        ost_next = ost_reg; opitch_next = opitch_reg; otime_next = otime_reg;
        case (cmd.op)
            dbps_pkg::OP_AT_INIT:
            begin
                cx_next = {8'b0, dist_reg, 16'b0};
                cy_next = cmd.first ? {{8{height_reg[dbps_pkg::HEIGHT_W-1]}}, height_reg, 16'b0}
                                    : {err_reg, 16'b0};
                z_next  = '0;
            end
            dbps_pkg::OP_CORDIC:
            begin
                if (up)
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    z_next  = z_reg + ang;
                end
                else
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    z_next  = z_reg - ang;
                end
            end
            dbps_pkg::OP_AT_DONE:
            begin
                pitch_next = cmd.first ? z_reg : pitch_reg + z_reg;
            end
            dbps_pkg::OP_ROT_INIT:
            begin
                cx_next = (CW'(speed_reg) * CW'(dbps_pkg::GAIN)) >> 2;
                cy_next = '0;
                z_next  = pitch_reg;
            end
            dbps_pkg::OP_ROT_DONE:
            begin
                vx_next = rnd_x[VW+13:14];
                vy_next = rnd_y[VW+13:14];
                x_next  = '0;
                y_next  = '0;
                n_next  = '0;
            end
            dbps_pkg::OP_HY_INIT:
            begin
                cx_next = {2'b0, ax, 14'b0};
                cy_next = {2'b0, ay, 14'b0};
                px_next = x_reg;
                py_next = y_reg;
                pn_next = n_reg;
            end
            dbps_pkg::OP_HY_MUL:
            begin
                prod_next = cx_reg[41:0] * dbps_pkg::GAIN;
            end
            dbps_pkg::OP_KV:
            begin
                kv_next = kvfull[2*dbps_pkg::K_W+3:dbps_pkg::K_W];
            end
            dbps_pkg::OP_MUL:
            begin
                m_next = $signed({1'b0, kv_reg})
                         * ((cmd.dsel == dbps_pkg::D_VX) ? vx_reg : vy_reg);
            end
            dbps_pkg::OP_DIVA:
            begin
                du_next = div_s[dbps_pkg::UW-1:0];
                dq_next = div_s[dbps_pkg::UW-1:0] * dbps_pkg::RECIP_25;
            end
            dbps_pkg::OP_DIVB:
            begin
                case (cmd.dsel)
                    dbps_pkg::D_VX: vx_next = vx_reg - div_res;
                    dbps_pkg::D_VY: vy_next = vy_reg - div_res;
                    dbps_pkg::D_X:  x_next  = x_reg + div_res;
                    dbps_pkg::D_Y:
                    begin
                        y_next = y_reg + div_res;
                        n_next = n_reg + 1'b1;
                    end
                    default:        time_next = div_res[dbps_pkg::TIME_W-1:0];
                endcase
            end
            dbps_pkg::OP_DV_INIT:
            begin
                den_next = VW'(x_reg - px_reg);
                rem_next = dbps_pkg::REMW'(span >> 1);
                nlo_next = {span[0], 16'b0};
                quo_next = '0;
            end
            dbps_pkg::OP_DV_ITER:
            begin
                nlo_next = nlo_reg << 1;
                if (trial >= dbps_pkg::REMW'(den_reg))
                begin
                    rem_next = trial - dbps_pkg::REMW'(den_reg);
                    quo_next = {quo_reg[dbps_pkg::RATIO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[dbps_pkg::RATIO_W-2:0], 1'b0};
                end
            end
            dbps_pkg::OP_HIT:
            begin
                m_next = dbps_pkg::MW'(dyy) * dbps_pkg::MW'(ratio_s);
            end
            dbps_pkg::OP_ERR:
            begin
                err_next = VW'(height_reg) - hit_y;
            end
            dbps_pkg::OP_OUT:
            begin
                ost_next = cmd.status;
                if (cmd.status == dbps_pkg::ST_SOLVED)
                begin
                    opitch_next = pitch_reg;
                    otime_next  = time_reg;
                end
                else
                begin
                    opitch_next = '0;
                    otime_next  = '0;
                end
            end
            default:
            begin
                cx_next = cx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            k_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == dbps_pkg::OP_LOAD)
        begin
            speed_reg  <= muzzle_speed;
            dist_reg   <= target_distance;
            height_reg <= target_height;
        end
        cx_reg <= cx_next;   cy_reg <= cy_next;   z_reg <= z_next;
        pitch_reg <= pitch_next;
        vx_reg <= vx_next;   vy_reg <= vy_next;   x_reg <= x_next;   y_reg <= y_next;
        px_reg <= px_next;   py_reg <= py_next;   n_reg <= n_next;   pn_reg <= pn_next;
        prod_reg <= prod_next;   kv_reg <= kv_next;   m_reg <= m_next;
        du_reg <= du_next;   dq_reg <= dq_next;
        rem_reg <= rem_next; quo_reg <= quo_next; nlo_reg <= nlo_next; den_reg <= den_next;
        err_reg <= err_next; time_reg <= time_next;
        ost_reg <= ost_next; opitch_reg <= opitch_next; otime_reg <= otime_next;
    end

    assign status      = ost_reg;
    assign pitch_angle = opitch_reg;
    assign flight_time = otime_reg;

endmodule

// ===== hdl/drag_ballistic_pitch_solver.sv =====
// Launch pitch solver for a point mass under gravity and quadratic drag.
// query (sink) takes one word of muzzle speed, target distance and target
// height; answer (source) returns one word of status, pitch and flight time
// per query word, in order. cfg_write_en/cfg_write_data load the drag
// coefficient; write it only while no query is in flight.
// A query word is taken only when the solver is idle; the result sits in an
// output register, so a new query is taken while an earlier answer waits.
// Each query runs a setup per attempt, then 5 ms integration steps, each
// using the shared CORDIC magnitude, then the multiplies and the
// divide-by-200 unit, and then a crossing divide. By default there are at
// most 10 attempts of up to 800 steps each; bad inputs are answered
// without an attempt.
// Reset clears the drag coefficient and the controller; no answer is
// pending after reset. When answer.ready is low the result is held and the
// solver finishes the current query, then waits before loading its answer.
module drag_ballistic_pitch_solver #(
    parameter int MAX_ATTEMPTS     = dbps_pkg::MAX_ATTEMPTS_DEF,
    parameter int MAX_FLIGHT_STEPS = dbps_pkg::MAX_FLIGHT_STEPS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_en,
    input  logic [dbps_pkg::K_W-1:0] cfg_write_data,
    dbps_query_if.sink               query,
    dbps_answer_if.source            answer
);

    dbps_pkg::cmd_t   cmd;
    dbps_pkg::flags_t flags;

    dbps_ctrl #(
        .MAX_ATTEMPTS (MAX_ATTEMPTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (query.valid),
        .in_ready  (query.ready),
        .out_valid (answer.valid),
        .out_ready (answer.ready),
        .flags     (flags),
        .cmd       (cmd)
    );

    dbps_dp #(
        .MAX_FLIGHT_STEPS (MAX_FLIGHT_STEPS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .muzzle_speed    (query.muzzle_speed),
        .target_distance (query.target_distance),
        .target_height   (query.target_height),
        .cmd             (cmd),
        .flags           (flags),
        .status          (answer.status),
        .pitch_angle     (answer.pitch_angle),
        .flight_time     (answer.flight_time)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        query.valid && query.ready |=> !query.ready)
        else $error("query taken while a solve is running");

    a_unsolved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        answer.valid && (answer.status != dbps_pkg::ST_SOLVED)
        |-> (answer.pitch_angle == '0) && (answer.flight_time == '0))
        else $error("unsolved answer carries non-zero pitch or time");

    a_no_instant_answer: assert property (@(posedge clk) disable iff (!rst_n)
        query.valid && query.ready && !answer.valid |=> !answer.valid)
        else $error("answer appeared one cycle after a query");

endmodule
